FILE: rtl/core/pse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Shared sizes, codes and control structs of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned STACK_DEPTH    = 16;
  localparam int unsigned VARIABLE_COUNT = 26;

  localparam int unsigned STK_AW = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VAR_AW = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

  typedef enum logic [2:0] {
    REQ_LOAD_VAR = 3'd0,
    REQ_PUSH_VAR = 3'd1,
    REQ_PUSH_LIT = 3'd2,
    REQ_OPERATOR = 3'd3,
    REQ_END      = 3'd4
  } req_type_e;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_AND = 4'd4,
    OP_OR  = 4'd5,
    OP_NE  = 4'd6,
    OP_GT  = 4'd7,
    OP_LT  = 4'd8,
    OP_LE  = 4'd9,
    OP_GE  = 4'd10
  } op_code_e;

  typedef enum logic [1:0] {
    STAT_ANSWER  = 2'd0,
    STAT_UNDER   = 2'd1,
    STAT_OVER    = 2'd2,
    STAT_DIVZERO = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VAR_RD,
    ST_STK_RD,
    ST_DIV,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/core/pse_tok_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_tok_if
// Token request channel: valid/ready handshake with one postfix token.
// ----------------------------------------------------------------------------
interface pse_tok_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       req_type;
  logic [4:0]                       var_index;
  logic signed [pse_pkg::DATA_W-1:0] operand_value;
  logic [3:0]                       op_code;

  modport source (output valid, output req_type, output var_index,
                  output operand_value, output op_code, input ready);
  modport sink   (input valid, input req_type, input var_index,
                  input operand_value, input op_code, output ready);
endinterface

FILE: rtl/core/pse_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_res_if
// Result channel: valid/ready handshake carrying answer and status.
// ----------------------------------------------------------------------------
interface pse_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [pse_pkg::DATA_W-1:0] answer;
  logic [1:0]                       status;

  modport source (output valid, output answer, output status, input ready);
  modport sink   (input valid, input answer, input status, output ready);
endinterface

FILE: rtl/core/pse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pse_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_div
// Radix-2 restoring divider, signed 32-bit, truncating toward zero.
// ----------------------------------------------------------------------------
module pse_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pse_pkg::div_req_t req_i,
  output pse_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W   = pse_pkg::DATA_W;
  localparam int unsigned CW  = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  mag_q, mag_d;
  logic          neg_q, neg_d;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, mag_q};
  assign fits    = (shifted >= {1'b0, mag_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend[W-1] ? (W'(0) - req_i.dividend) : req_i.dividend;
      mag_d  = req_i.divisor[W-1] ? (W'(0) - req_i.divisor) : req_i.divisor;
      neg_d  = req_i.dividend[W-1] ^ req_i.divisor[W-1];
    end else if (busy_q) begin
      rem_d = fits ? diff[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

FILE: rtl/core/pse_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_alu
// Combinational binary operators: add, sub, mul, logic and compares.
// ----------------------------------------------------------------------------
module pse_alu (
  input  logic [3:0]                 op_i,
  input  logic [pse_pkg::DATA_W-1:0] lhs_i,
  input  logic [pse_pkg::DATA_W-1:0] rhs_i,
  output logic [pse_pkg::DATA_W-1:0] res_o
);

  localparam int unsigned W = pse_pkg::DATA_W;

  logic [W-1:0] prod;
  logic         lt_lr;
  logic         lt_rl;

  // low half of the product only, wraps like the rest
  assign prod  = lhs_i * rhs_i;
  assign lt_lr = ($signed(lhs_i) < $signed(rhs_i));
  assign lt_rl = ($signed(rhs_i) < $signed(lhs_i));

  always_comb begin
    case (op_i)
      pse_pkg::OP_ADD: res_o = lhs_i + rhs_i;
      pse_pkg::OP_SUB: res_o = lhs_i - rhs_i;
      pse_pkg::OP_MUL: res_o = prod;
      pse_pkg::OP_AND: res_o = W'((lhs_i != '0) && (rhs_i != '0));
      pse_pkg::OP_OR:  res_o = W'((lhs_i != '0) || (rhs_i != '0));
      pse_pkg::OP_NE:  res_o = W'(lhs_i != rhs_i);
      pse_pkg::OP_GT:  res_o = W'(lt_rl);
      pse_pkg::OP_LT:  res_o = W'(lt_lr);
      pse_pkg::OP_LE:  res_o = W'(!lt_rl);
      pse_pkg::OP_GE:  res_o = W'(!lt_lr);
      default:         res_o = '0;
    endcase
  end

endmodule

FILE: rtl/core/postfix_stack_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Postfix token evaluator built around a stack RAM and a variable RAM.
// ----------------------------------------------------------------------------
// Tokens arrive on tok_i, one request per handshake, and results leave on
// res_o. The stack lives in a RAM with the top entry held in a register, so
// an operator needs one RAM read for its left operand. Variables live in a
// second RAM whose entries read as zero until first loaded.
// Load, literal push and end tokens are handled in the idle state; a variable
// push adds a variable RAM read, an operator adds a stack RAM read, and a
// divide also waits for the serial divider, which makes it the slowest token.
// A token that gives a result then passes the hand-off state, which loads
// it into the output register. Tokens are taken one at a time, while the
// previous result may still sit in the output register. If the receiver
// stalls and a new result is ready, the unit holds that result and takes no
// token until the output register is free. Reset empties the stack, clears
// the variables and the output valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  pse_tok_if.sink   tok_i,
  pse_res_if.source res_o
);

  localparam int unsigned W      = pse_pkg::DATA_W;
  localparam int unsigned CNT_W  = pse_pkg::CNT_W;
  localparam int unsigned STK_AW = pse_pkg::STK_AW;
  localparam int unsigned VAR_AW = pse_pkg::VAR_AW;
  localparam int unsigned VARS   = pse_pkg::VARIABLE_COUNT;

  pse_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [W-1:0]     top_q, top_d;
  logic [VARS-1:0]  var_vld_q, var_vld_d;
  logic [4:0]       idx_q, idx_d;
  logic [3:0]       op_q, op_d;
  logic [W-1:0]     res_ans_q, res_ans_d;
  logic [1:0]       res_st_q, res_st_d;
  logic             out_vld_q;
  logic [W-1:0]     out_ans_q;
  logic [1:0]       out_st_q;
  logic             out_load;

  logic              stk_we, stk_re;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;
  logic [W-1:0]      stk_wdata, stk_rdata;
  logic              var_we, var_re;
  logic [VAR_AW-1:0] var_addr;
  logic [W-1:0]      var_rdata;

  pse_pkg::div_req_t div_req;
  pse_pkg::div_rsp_t div_rsp;
  logic [W-1:0]      alu_res;

  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic             full, has_two, idx_ok, tok_acc;
  logic             push_en;
  logic [W-1:0]     push_val;

  assign cnt_m1  = count_q - CNT_W'(1);
  assign cnt_m2  = count_q - CNT_W'(2);
  assign full    = (count_q == CNT_W'(pse_pkg::STACK_DEPTH));
  assign has_two = (count_q >= CNT_W'(2));
  assign idx_ok  = (tok_i.var_index < 5'(VARS));
  assign tok_acc = tok_i.valid && tok_i.ready;

  assign tok_i.ready = (state_q == pse_pkg::ST_IDLE);

  pse_ram #(.WIDTH(W), .DEPTH(pse_pkg::STACK_DEPTH)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  pse_ram #(.WIDTH(W), .DEPTH(VARS)) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (var_we),
    .waddr_i (var_addr),
    .wdata_i (tok_i.operand_value),
    .re_i    (var_re),
    .raddr_i (var_addr),
    .rdata_o (var_rdata)
  );

  pse_alu u_alu (
    .op_i  (op_q),
    .lhs_i (stk_rdata),
    .rhs_i (top_q),
    .res_o (alu_res)
  );

  pse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    top_d     = top_q;
    var_vld_d = var_vld_q;
    idx_d     = idx_q;
    op_d      = op_q;
    res_ans_d = res_ans_q;
    res_st_d  = res_st_q;
    out_load  = 1'b0;
    stk_re    = 1'b0;
    stk_raddr = cnt_m2[STK_AW-1:0];
    var_we    = 1'b0;
    var_re    = 1'b0;
    var_addr  = tok_i.var_index[VAR_AW-1:0];
    push_en   = 1'b0;
    push_val  = tok_i.operand_value;
    div_req.start    = 1'b0;
    div_req.dividend = stk_rdata;
    div_req.divisor  = top_q;

    case (state_q)
      pse_pkg::ST_IDLE: begin
        if (tok_acc) begin
          idx_d = tok_i.var_index;
          op_d  = tok_i.op_code;
          case (tok_i.req_type)
            pse_pkg::REQ_LOAD_VAR: begin
              if (idx_ok) begin
                var_we = 1'b1;
                var_vld_d[tok_i.var_index[VAR_AW-1:0]] = 1'b1;
              end
            end
            pse_pkg::REQ_PUSH_VAR: begin
              if (full) begin
                res_ans_d = '0;
                res_st_d  = pse_pkg::STAT_OVER;
                state_d   = pse_pkg::ST_RESULT;
              end else if (idx_ok) begin
                var_re  = 1'b1;
                state_d = pse_pkg::ST_VAR_RD;
              end else begin
                push_en  = 1'b1;
                push_val = '0;
              end
            end
            pse_pkg::REQ_PUSH_LIT: begin
              if (full) begin
                res_ans_d = '0;
                res_st_d  = pse_pkg::STAT_OVER;
                state_d   = pse_pkg::ST_RESULT;
              end else begin
                push_en = 1'b1;
              end
            end
            pse_pkg::REQ_OPERATOR: begin
              if (!has_two) begin
                res_ans_d = '0;
                res_st_d  = pse_pkg::STAT_UNDER;
                state_d   = pse_pkg::ST_RESULT;
              end else begin
                stk_re  = 1'b1;
                state_d = pse_pkg::ST_STK_RD;
              end
            end
            pse_pkg::REQ_END: begin
              state_d = pse_pkg::ST_RESULT;
              if (count_q == '0) begin
                res_ans_d = '0;
                res_st_d  = pse_pkg::STAT_UNDER;
              end else begin
                res_ans_d = top_q;
                res_st_d  = pse_pkg::STAT_ANSWER;
                count_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      pse_pkg::ST_VAR_RD: begin
        // an entry never loaded reads as zero
        push_en  = 1'b1;
        push_val = var_vld_q[idx_q[VAR_AW-1:0]] ? var_rdata : '0;
        state_d  = pse_pkg::ST_IDLE;
      end
      pse_pkg::ST_STK_RD: begin
        if (op_q == pse_pkg::OP_DIV) begin
          if (top_q == '0) begin
            top_d     = '0;
            count_d   = cnt_m1;
            res_ans_d = '0;
            res_st_d  = pse_pkg::STAT_DIVZERO;
            state_d   = pse_pkg::ST_RESULT;
          end else begin
            div_req.start = 1'b1;
            state_d       = pse_pkg::ST_DIV;
          end
        end else begin
          top_d   = alu_res;
          count_d = cnt_m1;
          state_d = pse_pkg::ST_IDLE;
        end
      end
      pse_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          top_d   = div_rsp.quotient;
          count_d = cnt_m1;
          state_d = pse_pkg::ST_IDLE;
        end
      end
      pse_pkg::ST_RESULT: begin
        if (!out_vld_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = pse_pkg::ST_IDLE;
        end
      end
      default: state_d = pse_pkg::ST_IDLE;
    endcase

    // old top spills to the RAM, new value becomes the top
    stk_we    = push_en && (count_q != '0);
    stk_waddr = cnt_m1[STK_AW-1:0];
    stk_wdata = top_q;
    if (push_en) begin
      top_d   = push_val;
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      var_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      var_vld_q <= var_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    idx_q     <= idx_d;
    op_q      <= op_d;
    res_ans_q <= res_ans_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_ans_q <= res_ans_q;
      out_st_q  <= res_st_q;
    end
  end

  assign res_o.valid  = out_vld_q;
  assign res_o.answer = out_ans_q;
  assign res_o.status = out_st_q;

  // divider only reports while the unit waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == pse_pkg::ST_DIV))
    else $error("divider done outside divide wait");

  // a new result only appears after the hand-off state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> ($past(state_q) == pse_pkg::ST_RESULT))
    else $error("result appeared without hand-off");

  // an end token on a non-empty stack leaves it empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_acc && (tok_i.req_type == pse_pkg::REQ_END) && (count_q != '0))
      |=> (count_q == '0))
    else $error("stack not emptied by end token");

  // a literal pushed onto a full stack is dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_acc && (tok_i.req_type == pse_pkg::REQ_PUSH_LIT) && full)
      |=> (count_q == $past(count_q)))
    else $error("overflowing push changed the stack");

endmodule
